@@ src/ihcf_pkg.sv @@
// Package for the IPv4 header checksum fixup block.
// Constants, state encoding and control structs; no dependencies.
package ihcf_pkg;

    localparam int HOLD_LEN  = 34;
    localparam int POS_W     = 6;
    localparam int SUM_W     = 20;
    localparam int CSUM_HI   = 24;
    localparam int CSUM_LO   = 25;
    localparam int IP_START  = 14;
    localparam int TYPE_HI   = 12;
    localparam int TYPE_LO   = 13;

    localparam logic [SUM_W-1:0] SUM_INIT     = SUM_W'(20'h0ffff);
    localparam logic [7:0]       ETYPE_IPV4_HI = 8'h08;
    localparam logic [7:0]       ETYPE_IPV4_LO = 8'h00;

    typedef enum logic [2:0] {
        S_FILL  = 3'b001,
        S_DRAIN = 3'b010,
        S_PASS  = 3'b100
    } state_t;

    typedef struct packed {
        logic             valid;
        logic             clear;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } hdr_sum_ctl_t;

    typedef struct packed {
        logic        ipv4;
        logic [15:0] csum;
    } hdr_sum_sts_t;

endpackage

@@ src/ihcf_stream_if.sv @@
// Byte stream channel: valid/ready handshake with data byte and last marker.
// No dependencies.
interface ihcf_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    logic       last;

    modport source (output valid, output data, output last, input ready);
    modport sink   (input valid, input data, input last, output ready);
endinterface

@@ src/ihcf_hold_ram.sv @@
// Hold buffer for the first header bytes of a frame: 1W/1R synchronous RAM.
// Depends on ihcf_pkg for depth and address width.
module ihcf_hold_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ihcf_pkg::POS_W-1:0] waddr,
    input  logic [7:0]                wdata,
    input  logic                      re,
    input  logic [ihcf_pkg::POS_W-1:0] raddr,
    output logic [7:0]                rdata
);
    import ihcf_pkg::*;

    logic [7:0] mem [HOLD_LEN];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ihcf_hdr_sum.sv @@
// Running IPv4 header sum, EtherType match and folded checksum.
// Depends on ihcf_pkg.
module ihcf_hdr_sum (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ihcf_pkg::hdr_sum_ctl_t     ctl,
    output ihcf_pkg::hdr_sum_sts_t     sts
);
    import ihcf_pkg::*;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             ipv4_reg, ipv4_next;
    logic [7:0]       prev_reg;
    logic [7:0]       type_hi_reg;
    logic             add_word;
    logic [16:0]      fold1;
    logic [15:0]      fold2;

    assign add_word = ctl.valid && (ctl.pos >= POS_W'(IP_START + 1)) && ctl.pos[0]
                      && (ctl.pos != POS_W'(CSUM_LO));

    always_comb
    begin
        sum_next  = sum_reg;
        ipv4_next = ipv4_reg;
        if (ctl.clear)
        begin
            sum_next  = SUM_INIT;
            ipv4_next = 1'b0;
        end
        else
        begin
            if (add_word)
            begin
                sum_next = sum_reg + {{(SUM_W-16){1'b0}}, prev_reg, ctl.data};
            end
            if (ctl.valid && ctl.pos == POS_W'(TYPE_LO))
            begin
                ipv4_next = (type_hi_reg == ETYPE_IPV4_HI) && (ctl.data == ETYPE_IPV4_LO);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= SUM_INIT;
            ipv4_reg <= 1'b0;
        end
        else
        begin
            sum_reg  <= sum_next;
            ipv4_reg <= ipv4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            prev_reg <= ctl.data;
        end
        if (ctl.valid && ctl.pos == POS_W'(TYPE_HI))
        begin
            type_hi_reg <= ctl.data;
        end
    end

    // two end-around folds cover a 20-bit sum
    assign fold1 = {1'b0, sum_reg[15:0]} + {13'b0, sum_reg[SUM_W-1:16]};
    assign fold2 = fold1[15:0] + {15'b0, fold1[16]};

    assign sts.ipv4 = ipv4_reg;
    assign sts.csum = ~fold2;

endmodule

@@ src/ipv4_header_checksum_fixup.sv @@
// Top level of the IPv4 header checksum fixup block.
// Depends on ihcf_pkg, ihcf_stream_if, ihcf_hold_ram and ihcf_hdr_sum.
//
// Usage:
//   rx takes frame bytes, one word per handshake, with last on the final byte.
//   tx gives the same frame; for IPv4 (EtherType 0x0800) bytes 24 and 25
//   carry the recomputed header checksum.
//   The first 34 bytes are written into the hold RAM at one byte per cycle
//   and none of them leaves meanwhile. A frame shorter than 34 bytes drains
//   unchanged once its last byte arrives.
//   After byte 33 the held bytes drain from the RAM read port, one per cycle
//   while tx is ready; the first one passes the RAM read register and then
//   the output register. rx is held off during the drain. Later bytes then
//   pass through the output register at one per cycle while tx is ready.
//   A tx stall holds the output word and, in pass-through, stops rx.
//   Reset clears the control state; RAM contents are left undefined and are
//   never read before being written.
module ipv4_header_checksum_fixup (
    input  logic          clk,
    input  logic          rst_n,
    ihcf_stream_if.sink   rx,
    ihcf_stream_if.source tx
);
    import ihcf_pkg::*;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] n_reg, n_next;
    logic             frame_last_reg, frame_last_next;
    logic [POS_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             pend_reg, pend_next;
    logic [POS_W-1:0] pend_idx_reg, pend_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic             rx_acc, fill_acc, pass_acc;
    logic             load, issue, drain_done, fix;
    logic [7:0]       rdata;
    logic [7:0]       drain_byte;
    hdr_sum_ctl_t     sum_ctl;
    hdr_sum_sts_t     sum_sts;

    assign rx.ready = (state_reg == S_FILL)
                   || ((state_reg == S_PASS) && (!out_valid_reg || tx.ready));
    assign rx_acc   = rx.valid && rx.ready;
    assign fill_acc = rx_acc && (state_reg == S_FILL);
    assign pass_acc = rx_acc && (state_reg == S_PASS);

    assign load       = pend_reg && (!out_valid_reg || tx.ready);
    assign issue      = (state_reg == S_DRAIN) && (rd_cnt_reg != n_reg) && (!pend_reg || load);
    assign drain_done = (state_reg == S_DRAIN) && (rd_cnt_reg == n_reg) && !pend_reg;
    assign fix        = (n_reg == POS_W'(HOLD_LEN)) && sum_sts.ipv4;

    ihcf_hold_ram u_ram (
        .clk   (clk),
        .we    (fill_acc),
        .waddr (pos_reg),
        .wdata (rx.data),
        .re    (issue),
        .raddr (rd_cnt_reg),
        .rdata (rdata)
    );

    assign sum_ctl.valid = fill_acc;
    assign sum_ctl.clear = drain_done;
    assign sum_ctl.pos   = pos_reg;
    assign sum_ctl.data  = rx.data;

    ihcf_hdr_sum u_sum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sum_ctl),
        .sts   (sum_sts)
    );

    always_comb
    begin
        drain_byte = rdata;
        if (fix && pend_idx_reg == POS_W'(CSUM_HI))
        begin
            drain_byte = sum_sts.csum[15:8];
        end
        else if (fix && pend_idx_reg == POS_W'(CSUM_LO))
        begin
            drain_byte = sum_sts.csum[7:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        frame_last_next = frame_last_reg;
        rd_cnt_next     = rd_cnt_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;

        if (out_valid_reg && tx.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_FILL:
            begin
                if (fill_acc)
                begin
                    pos_next = pos_reg + 1'b1;
                    if (rx.last || pos_reg == POS_W'(HOLD_LEN - 1))
                    begin
                        n_next          = pos_reg + 1'b1;
                        frame_last_next = rx.last;
                        rd_cnt_next     = '0;
                        state_next      = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = drain_byte;
                    out_last_next  = frame_last_reg && (pend_idx_reg == n_reg - 1'b1);
                end
                if (issue)
                begin
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                    pend_idx_next = rd_cnt_reg;
                    pend_next     = 1'b1;
                end
                else if (load)
                begin
                    pend_next = 1'b0;
                end
                if (drain_done)
                begin
                    pos_next   = '0;
                    state_next = frame_last_reg ? S_FILL : S_PASS;
                end
            end
            S_PASS:
            begin
                if (pass_acc)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rx.data;
                    out_last_next  = rx.last;
                    if (rx.last)
                    begin
                        state_next = S_FILL;
                    end
                end
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FILL;
            pos_reg        <= '0;
            n_reg          <= '0;
            frame_last_reg <= 1'b0;
            rd_cnt_reg     <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            n_reg          <= n_next;
            frame_last_reg <= frame_last_next;
            rd_cnt_reg     <= rd_cnt_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign tx.valid = out_valid_reg;
    assign tx.data  = out_byte_reg;
    assign tx.last  = out_last_reg;

endmodule

@@ src/ihcf_checker.sv @@
// Port-level checker for ipv4_header_checksum_fixup, with its bind.
// Depends on ihcf_pkg.
module ihcf_checker (
    input logic clk,
    input logic rst_n,
    input logic rx_valid,
    input logic rx_ready,
    input logic tx_valid,
    input logic tx_ready,
    input logic tx_last
);
    import ihcf_pkg::*;

    logic [POS_W:0] inflight_reg, inflight_next;
    logic           rx_acc, tx_acc;

    assign rx_acc = rx_valid && rx_ready;
    assign tx_acc = tx_valid && tx_ready;

    always_comb
    begin
        inflight_next = inflight_reg + {{POS_W{1'b0}}, rx_acc} - {{POS_W{1'b0}}, tx_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_last))
        else $error("tx word dropped while stalled");

    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !tx_valid)
        else $error("tx valid during reset");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= (POS_W+1)'(HOLD_LEN + 1))
        else $error("more words held than the header buffer allows");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == '0 |-> !tx_valid)
        else $error("tx word with nothing received");

endmodule

bind ipv4_header_checksum_fixup ihcf_checker u_ihcf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .tx_valid (tx.valid),
    .tx_ready (tx.ready),
    .tx_last  (tx.last)
);

@@ tb/sv/tb_ipv4_header_checksum_fixup.sv @@
`timescale 1ns / 1ps
// Testbench for ipv4_header_checksum_fixup: random and directed Ethernet frames,
// checked byte for byte against a predictor of the header checksum rewrite.
// Depends on ihcf_pkg, ihcf_stream_if and the block's RTL.
module tb_ipv4_header_checksum_fixup;
    import ihcf_pkg::*;

    localparam int FILL_RAND   = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZERO   = 2;

    localparam int ET_IPV4     = 0;
    localparam int ET_HI_ONLY  = 1;
    localparam int ET_LO_ONLY  = 2;
    localparam int ET_RAND     = 3;

    localparam int RAND_ITEMS  = 100;
    localparam int MAX_GAP     = 6;
    localparam int CALM_FIRST  = 150;
    localparam int CALM_LAST   = 230;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 40;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_PRINTS  = 50;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain_first;
    } frame_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } word_t;

    logic clk;
    logic rst_n;

    ihcf_stream_if rx_if ();
    ihcf_stream_if tx_if ();

    ipv4_header_checksum_fixup uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if)
    );

    frame_byte_t frame_q[$];
    word_t       release_q[$];

    logic [7:0]       hdr_hold [HOLD_LEN];
    logic [POS_W-1:0] hdr_pos;
    logic [SUM_W-1:0] hdr_sum;
    bit               is_ipv4;
    bit               streaming;

    int          err_cnt;
    int          in_cnt;
    int          out_cnt;
    int          quiet;
    bit          offered;
    int          gap;
    frame_byte_t cur;
    int          stall;
    int          hold_left;
    bit          hold_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic log_mismatch(string msg);
        if (err_cnt < MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic void fixup_restart();
        hdr_pos   = '0;
        hdr_sum   = SUM_INIT;
        is_ipv4   = 1'b0;
        streaming = 1'b0;
    endfunction

    function automatic void fixup_predict(logic [7:0] b, logic last);
        int               p;
        logic [SUM_W-1:0] s;
        logic [15:0]      c;
        if (streaming)
        begin
            release_q.push_back('{b, last});
            if (last)
                fixup_restart();
            return;
        end
        p = hdr_pos;
        hdr_hold[p] = b;
        if (p == TYPE_LO)
            is_ipv4 = (hdr_hold[TYPE_HI] == ETYPE_IPV4_HI) && (b == ETYPE_IPV4_LO);
        if (p >= IP_START + 1 && (p % 2) == 1 && p != CSUM_LO)
            hdr_sum = hdr_sum + {hdr_hold[p-1], b};
        hdr_pos = POS_W'(p + 1);
        if (p + 1 < HOLD_LEN)
        begin
            if (!last)
                return;
            for (int i = 0; i <= p; i++)
                release_q.push_back('{hdr_hold[i], i == p});
            fixup_restart();
            return;
        end
        if (is_ipv4)
        begin
            s = hdr_sum;
            while (s[SUM_W-1:16] != '0)
                s = s[15:0] + s[SUM_W-1:16];
            c = ~s[15:0];
            hdr_hold[CSUM_HI] = c[15:8];
            hdr_hold[CSUM_LO] = c[7:0];
        end
        for (int i = 0; i < HOLD_LEN; i++)
            release_q.push_back('{hdr_hold[i], (i == HOLD_LEN - 1) ? last : 1'b0});
        if (last)
            fixup_restart();
        else
            streaming = 1'b1;
    endfunction

    task automatic add_frame(int len, int fill, int etype, bit drain_first);
        frame_byte_t fb;
        logic [7:0]  v;
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ONES: v = 8'hff;
                FILL_ZERO: v = 8'h00;
                default:   v = 8'($urandom_range(0, 255));
            endcase
            if (i == TYPE_HI)
            begin
                case (etype)
                    ET_IPV4, ET_HI_ONLY: v = ETYPE_IPV4_HI;
                    ET_LO_ONLY: if (v == ETYPE_IPV4_HI) v = v ^ 8'h01;
                    default: ;
                endcase
            end
            if (i == TYPE_LO)
            begin
                case (etype)
                    ET_IPV4, ET_LO_ONLY: v = ETYPE_IPV4_LO;
                    ET_HI_ONLY: if (v == ETYPE_IPV4_LO) v = v ^ 8'h80;
                    default: ;
                endcase
            end
            fb.data        = v;
            fb.last        = (i == len - 1);
            fb.drain_first = drain_first && (i == 0);
            frame_q.push_back(fb);
        end
    endtask

    // rx driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_if.valid <= 1'b0;
            rx_if.data  <= '0;
            rx_if.last  <= 1'b0;
            offered = 1'b0;
            gap     = 0;
        end
        else
        begin
            if (rx_if.valid && rx_if.ready)
            begin
                fixup_predict(cur.data, cur.last);
                in_cnt++;
                offered = 1'b0;
                gap = (in_cnt >= CALM_FIRST && in_cnt < CALM_LAST) ? 0 :
                      $urandom_range(0, MAX_GAP);
            end
            if (!offered)
            begin
                if (gap > 0)
                    gap--;
                else if (frame_q.size() != 0 &&
                         !(frame_q[0].drain_first && release_q.size() != 0))
                begin
                    cur = frame_q.pop_front();
                    rx_if.data <= cur.data;
                    rx_if.last <= cur.last;
                    offered = 1'b1;
                end
            end
            rx_if.valid <= offered;
        end
    end

    // tx monitor and checker
    always @(posedge clk)
    begin
        word_t w;
        if (!rst_n)
        begin
            tx_if.ready <= 1'b0;
            stall     = 0;
            hold_left = 0;
        end
        else
        begin
            if (tx_if.valid && tx_if.ready)
            begin
                out_cnt++;
                if (release_q.size() == 0)
                    log_mismatch($sformatf("unexpected word %02h last %0b",
                                           tx_if.data, tx_if.last));
                else
                begin
                    w = release_q.pop_front();
                    if (tx_if.data !== w.data)
                        log_mismatch($sformatf("word %0d: byte expected %02h got %02h",
                                               out_cnt, w.data, tx_if.data));
                    if (tx_if.last !== w.last)
                        log_mismatch($sformatf("word %0d: last expected %0b got %0b",
                                               out_cnt, w.last, tx_if.last));
                end
                stall = (out_cnt >= CALM_FIRST && out_cnt < CALM_LAST) ? 0 :
                        $urandom_range(0, MAX_GAP);
            end
            if (!hold_done && out_cnt >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tx_if.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                tx_if.ready <= 1'b0;
            end
            else
                tx_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int len;
        int etype;
        int rand_items;
        rst_n       = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.data  = '0;
        rx_if.last  = 1'b0;
        tx_if.ready = 1'b0;
        err_cnt     = 0;
        in_cnt      = 0;
        out_cnt     = 0;
        quiet       = 0;
        hold_done   = 1'b0;
        fixup_restart();

        // directed: one-byte frame, short IPv4 frames, exact header, zero header,
        // near-miss EtherTypes
        add_frame(1, FILL_ONES, ET_RAND, 1'b0);
        add_frame(14, FILL_ZERO, ET_IPV4, 1'b0);
        add_frame(33, FILL_RAND, ET_IPV4, 1'b0);
        add_frame(HOLD_LEN, FILL_ONES, ET_IPV4, 1'b0);
        add_frame(HOLD_LEN + 1, FILL_ZERO, ET_IPV4, 1'b1);
        add_frame(HOLD_LEN, FILL_RAND, ET_HI_ONLY, 1'b0);
        add_frame(HOLD_LEN + 2, FILL_RAND, ET_LO_ONLY, 1'b0);

        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1:    len = $urandom_range(1, HOLD_LEN - 1);
                2:       len = HOLD_LEN;
                default: len = $urandom_range(HOLD_LEN, 64);
            endcase
            case ($urandom_range(0, 9))
                0:       etype = ET_HI_ONLY;
                1:       etype = ET_LO_ONLY;
                2:       etype = ET_RAND;
                default: etype = ET_IPV4;
            endcase
            add_frame(len, FILL_RAND, etype, $urandom_range(0, 9) == 0);
            rand_items += len;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (frame_q.size() != 0 || rx_if.valid)
            @(negedge clk);
        while (release_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (release_q.size() != 0)
            log_mismatch($sformatf("%0d words never came", release_q.size()));

        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
